>>> src/pwm_period_prescaler_solver_top_defines.svh
// assertion macros shared by the pwm period and prescaler solver rtl
// expects signals clk and rst_n in the scope of each use
`ifndef PWM_PERIOD_PRESCALER_SOLVER_TOP_DEFINES_SVH
`define PWM_PERIOD_PRESCALER_SOLVER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define PPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/pps_pkg.sv
// shared types and constants for the pwm period and prescaler solver
// no dependencies
`default_nettype none

package pps_pkg;

    localparam int OP_W   = 32;
    localparam int PROD_W = 2 * OP_W;
    localparam int STEP_W = $clog2(PROD_W);
    localparam int CLK_W  = 28;
    // clock_rate * period / 1e9 stays below 2^31
    localparam int FULL_W = 31;

    localparam logic [CLK_W-1:0] CLK_RATE_RESET = CLK_W'(32768);
    localparam logic [OP_W-1:0]  NS_PER_S       = OP_W'(1000000000);

    localparam logic [31:0] RELOAD_MAX_DEF  = 32'd65535;
    localparam logic [31:0] PRESC_LIMIT_DEF = 32'd128;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_PRESC = 2'd2;
    localparam logic [1:0] STAT_BUSY  = 2'd3;

    typedef struct packed {
        logic        enable_req;
        logic [31:0] period_ns;
        logic [31:0] duty_ns;
        logic        shared_locked;
        logic [2:0]  current_presc;
        logic [15:0] current_reload;
    } pps_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  presc_exp;
        logic [15:0] reload_value;
        logic [15:0] compare_value;
    } pps_out_t;

    // request to the multiply-divide unit: q = a * b / d
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
        logic [OP_W-1:0] d;
    } pps_md_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] q;
    } pps_md_rsp_t;

endpackage

`default_nettype wire

>>> src/pps_muldiv.sv
// bit-serial multiply then restoring divide: q = a * b / d
// depends on pps_pkg and the assertion macro header
`default_nettype none
`include "pwm_period_prescaler_solver_top_defines.svh"

module pps_muldiv
    import pps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pps_md_req_t req,
    output pps_md_rsp_t      rsp
);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [OP_W-1:0]   a_reg, b_reg, d_reg, rem_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [OP_W-1:0]   a_sel;
    logic [PROD_W-1:0] mul_sum;
    logic [OP_W:0]     shifted, diff;
    logic              ge;
    logic              mul_last, div_last;

    always_comb
    begin
        a_sel    = b_reg[OP_W-1] ? a_reg : '0;
        mul_sum  = {acc_reg[PROD_W-2:0], 1'b0} + {{OP_W{1'b0}}, a_sel};
        // bring down the next dividend bit
        shifted  = {rem_reg, acc_reg[PROD_W-1]};
        diff     = shifted - {1'b0, d_reg};
        ge       = shifted >= {1'b0, d_reg};
        mul_last = step_reg == STEP_W'(OP_W - 1);
        div_last = step_reg == STEP_W'(PROD_W - 1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL:  if (mul_last) state_next = MD_DIV;
            MD_DIV:  if (div_last) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MD_DIV) && div_last;
            if (state_reg == MD_IDLE || (state_reg == MD_MUL && mul_last))
                step_reg <= '0;
            else
                step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    d_reg   <= req.d;
                    acc_reg <= '0;
                end
            end
            MD_MUL:
            begin
                acc_reg <= mul_sum;
                b_reg   <= {b_reg[OP_W-2:0], 1'b0};
                rem_reg <= '0;
            end
            MD_DIV:
            begin
                rem_reg <= ge ? diff[OP_W-1:0] : shifted[OP_W-1:0];
                acc_reg <= {acc_reg[PROD_W-2:0], ge};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.q    = acc_reg;

    `PPS_ASSERT_IMP(a_start_idle, req.start, state_reg == MD_IDLE)
    `PPS_ASSERT_NXT(a_done_end, state_reg == MD_DIV && div_last, done_reg && state_reg == MD_IDLE)
    `PPS_ASSERT_IMP(a_rem_below_d, state_reg == MD_DIV, rem_reg < d_reg)

endmodule

`default_nettype wire

>>> src/pwm_period_prescaler_solver_top.sv
// pwm period and prescaler solver, top level
// depends on pps_pkg, pps_muldiv and the assertion macro header
//
// usage:
//  - cfg_we/cfg_wdata write the timer clock rate in hertz (reset 32768);
//    write it only while the block is idle
//  - an input item (in_valid/in_ready, in_data) is a pwm request; each item
//    gives exactly one result item on out_valid/out_ready, out_data
//  - a disable request goes to S_FIN and sets out_valid once out_reg is free
//  - an enabled request runs one pass of the bit-serial multiply-divide unit
//    (32 multiply steps, 64 divide steps) for the tick count, up to
//    1 + log2(PRESC_LIMIT) prescaler scaling steps, then a second pass for
//    the duty ticks; a period below one tick skips the scaling and the
//    second pass
//  - one item is worked on at a time; in_ready is high while idle
//  - results land in an output register, so a new item is taken while the
//    previous result waits; a stalled receiver holds the next finished
//    result in the solver until the output register frees up
//  - reset clears the control state and the output valid flag
`default_nettype none
`include "pwm_period_prescaler_solver_top_defines.svh"

module pwm_period_prescaler_solver_top
    import pps_pkg::*;
#(
    parameter logic [31:0] RELOAD_MAX  = RELOAD_MAX_DEF,
    parameter logic [31:0] PRESC_LIMIT = PRESC_LIMIT_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CLK_W-1:0] cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pps_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pps_out_t              out_data
);

    function automatic int floor_log2(input logic [31:0] v);
        int r;
        r = 0;
        for (int i = 0; i < 32; i++)
            if ((v >> i) != 32'd0)
                r = i;
        return r;
    endfunction

    localparam int EXP_MAX = floor_log2(PRESC_LIMIT);
    localparam int EXP_W   = $clog2(EXP_MAX + 2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL1  = 5'b00010,
        S_SCALE = 5'b00100,
        S_MUL2  = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic               out_valid_reg;
    logic [CLK_W-1:0]   clock_rate_reg;
    logic [EXP_W-1:0]   exp_reg;

    pps_in_t            in_reg;
    logic [FULL_W-1:0]  cnt_reg;
    pps_out_t           res_reg, out_reg;

    pps_md_req_t        md_req;
    pps_md_rsp_t        md_rsp;

    logic               in_acc, over, at_lim, busy_hit, fin_load, full_zero;
    logic [FULL_W-1:0]  reload_full;

    pps_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        in_ready    = state_reg == S_IDLE;
        in_acc      = in_valid && in_ready;
        over        = 32'(cnt_reg) > RELOAD_MAX;
        at_lim      = 32'(exp_reg) == 32'(EXP_MAX);
        reload_full = cnt_reg - FULL_W'(1);
        busy_hit    = in_reg.shared_locked
                      && (32'(in_reg.current_presc) != 32'(exp_reg)
                          || 32'(in_reg.current_reload) != 32'(reload_full));
        full_zero   = md_rsp.q[FULL_W-1:0] == '0;
        fin_load    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

        md_req.start = (in_acc && in_data.enable_req) || (state_reg == S_SCALE && !over);
        if (state_reg == S_IDLE)
        begin
            md_req.a = OP_W'(clock_rate_reg);
            md_req.b = in_data.period_ns;
            md_req.d = NS_PER_S;
        end
        else
        begin
            md_req.a = OP_W'(cnt_reg);
            md_req.b = in_reg.duty_ns;
            md_req.d = in_reg.period_ns;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = in_data.enable_req ? S_MUL1 : S_FIN;
            S_MUL1:
                if (md_rsp.done)
                    state_next = full_zero ? S_FIN : S_SCALE;
            S_SCALE:
                if (over)
                    state_next = at_lim ? S_FIN : S_SCALE;
                else
                    state_next = S_MUL2;
            S_MUL2:
                if (md_rsp.done)
                    state_next = S_FIN;
            S_FIN:
                if (fin_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            clock_rate_reg <= CLK_RATE_RESET;
            exp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                clock_rate_reg <= cfg_wdata;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_MUL1)
                exp_reg <= '0;
            else if (state_reg == S_SCALE && over && !at_lim)
                exp_reg <= exp_reg + EXP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_reg <= in_data;
            if (!in_data.enable_req)
                res_reg <= '{status: STAT_OK, default: '0};
        end
        if (state_reg == S_MUL1 && md_rsp.done)
        begin
            cnt_reg <= md_rsp.q[FULL_W-1:0];
            if (full_zero)
                res_reg <= '{status: STAT_SHORT, default: '0};
        end
        if (state_reg == S_SCALE && over)
        begin
            cnt_reg <= cnt_reg >> 1;
            if (at_lim)
                res_reg <= '{status: STAT_PRESC, default: '0};
        end
        if (state_reg == S_MUL2 && md_rsp.done)
        begin
            if (busy_hit)
                res_reg <= '{status: STAT_BUSY, default: '0};
            else
            begin
                res_reg.status        <= STAT_OK;
                res_reg.presc_exp     <= 3'(exp_reg);
                res_reg.reload_value  <= reload_full[15:0];
                // only the low bits of the duty ticks matter after the wrap
                res_reg.compare_value <= reload_full[15:0] - md_rsp.q[15:0];
            end
        end
        if (fin_load)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PPS_ASSERT_NXT(a_disable_fin, in_acc && !in_data.enable_req, state_reg == S_FIN)
    `PPS_ASSERT_IMP(a_done_in_mul, md_rsp.done, state_reg == S_MUL1 || state_reg == S_MUL2)
    `PPS_ASSERT_IMP(a_exp_limit, state_reg == S_SCALE, 32'(exp_reg) <= 32'(EXP_MAX))
    `PPS_ASSERT_IMP(a_err_zero, out_valid_reg && out_reg.status != STAT_OK,
        out_reg.presc_exp == '0 && out_reg.reload_value == '0 && out_reg.compare_value == '0)

endmodule

`default_nettype wire
